FILE: rtl/sha1sh_pkg.sv
// shared types, constants and controller command word for the sha-1 stream hasher
`default_nettype none

package sha1sh_pkg;

    localparam logic [0:4][31:0] H_INIT = {
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] ROUND_Q1   = 7'd20;
    localparam logic [6:0] ROUND_Q2   = 7'd40;
    localparam logic [6:0] ROUND_Q3   = 7'd60;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD80,
        ST_PADZERO,
        ST_LEN,
        ST_DIGEST
    } sh_state_t;

    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_PAD,
        BSEL_ZERO
    } byte_sel_t;

    typedef struct packed {
        logic      byte_wr;
        byte_sel_t byte_sel;
        logic [5:0] offset;
        logic      count_bits;
        logic      len_wr;
        logic      load_work;
        logic      round_en;
        logic [6:0] round_idx;
        logic      add_chain;
        logic      finish;
    } dp_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/sha1sh_ctrl.sv
// controller state machine: byte intake, padding sequence, round count and digest hand-off
`default_nettype none

module sha1sh_ctrl
    import sha1sh_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire logic    byte_present,
    input  wire logic    end_of_message,
    output logic         digest_valid,
    input  wire logic    digest_stall,
    output dp_cmd_t      cmd
);

    sh_state_t  state_reg, state_next;
    sh_state_t  after_reg, after_next;
    logic [5:0] offset_reg, offset_next;
    logic [6:0] round_reg, round_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            after_reg     <= ST_IDLE;
            offset_reg    <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            offset_reg    <= offset_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        after_next     = after_reg;
        offset_next    = offset_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg && digest_stall;
        item_stall     = 1'b1;
        cmd            = '0;
        cmd.byte_sel   = BSEL_DATA;
        cmd.offset     = offset_reg;
        cmd.round_idx  = round_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    if (byte_present)
                    begin
                        cmd.byte_wr    = 1'b1;
                        cmd.count_bits = 1'b1;
                        offset_next    = offset_reg + 6'd1;
                        if (offset_reg == BLOCK_LAST)
                        begin
                            cmd.load_work = 1'b1;
                            round_next    = '0;
                            state_next    = ST_ROUND;
                            after_next    = end_of_message ? ST_PAD80 : ST_IDLE;
                        end
                        else if (end_of_message)
                        begin
                            state_next = ST_PAD80;
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_ADD;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end
            ST_ADD:
            begin
                cmd.add_chain = 1'b1;
                state_next    = after_reg;
            end
            ST_PAD80:
            begin
                cmd.byte_wr  = 1'b1;
                cmd.byte_sel = BSEL_PAD;
                offset_next  = offset_reg + 6'd1;
                if (offset_reg == BLOCK_LAST)
                begin
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    state_next    = ST_ROUND;
                    after_next    = ST_PADZERO;
                end
                else
                begin
                    state_next = ST_PADZERO;
                end
            end
            ST_PADZERO:
            begin
                if (offset_reg == LEN_OFFSET)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    cmd.byte_wr  = 1'b1;
                    cmd.byte_sel = BSEL_ZERO;
                    offset_next  = offset_reg + 6'd1;
                    if (offset_reg == BLOCK_LAST)
                    begin
                        cmd.load_work = 1'b1;
                        round_next    = '0;
                        state_next    = ST_ROUND;
                        after_next    = ST_PADZERO;
                    end
                end
            end
            ST_LEN:
            begin
                cmd.len_wr    = 1'b1;
                cmd.load_work = 1'b1;
                round_next    = '0;
                state_next    = ST_ROUND;
                after_next    = ST_DIGEST;
            end
            ST_DIGEST:
            begin
                if (!out_valid_reg || !digest_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    offset_next    = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign digest_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/sha1sh_datapath.sv
// datapath: block buffer and schedule shift line, round unit, chaining value, bit count, digest register
`default_nettype none

module sha1sh_datapath
    import sha1sh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire logic [7:0]  data_byte,
    output logic [31:0]      digest_word0,
    output logic [31:0]      digest_word1,
    output logic [31:0]      digest_word2,
    output logic [31:0]      digest_word3,
    output logic [31:0]      digest_word4
);

    logic [31:0]      block_reg [16];
    logic [31:0]      block_next [16];
    logic [0:4][31:0] chain_reg, chain_next;
    logic [0:4][31:0] digest_reg, digest_next;
    logic [63:0]      bits_reg, bits_next;
    logic [31:0]      a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]      a_next, b_next, c_next, d_next, e_next;

    logic [7:0]  byte_val;
    logic [4:0]  lane_shift;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] temp_val;
    logic [31:0] sched_mix;
    logic [31:0] sched_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= H_INIT;
            bits_reg  <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
            bits_reg  <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        block_reg  <= block_next;
        digest_reg <= digest_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
    end

    // byte source and lane within the word
    always_comb
    begin
        unique case (cmd.byte_sel)
            BSEL_DATA: byte_val = data_byte;
            BSEL_PAD:  byte_val = PAD_BYTE;
            BSEL_ZERO: byte_val = 8'h00;
            default:   byte_val = 8'h00;
        endcase
        lane_shift = {~cmd.offset[1:0], 3'b000};
    end

    // round function
    always_comb
    begin
        priority if (cmd.round_idx < ROUND_Q1)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_ROUND0;
        end
        else if (cmd.round_idx < ROUND_Q2)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_ROUND1;
        end
        else if (cmd.round_idx < ROUND_Q3)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_ROUND2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_ROUND3;
        end
        temp_val  = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + block_reg[0];
        sched_mix = block_reg[13] ^ block_reg[8] ^ block_reg[2] ^ block_reg[0];
        sched_new = {sched_mix[30:0], sched_mix[31]};
    end

    always_comb
    begin
        block_next  = block_reg;
        chain_next  = chain_reg;
        digest_next = digest_reg;
        bits_next   = bits_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        e_next      = e_reg;

        if (cmd.byte_wr)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (cmd.offset[5:2] == 4'(i))
                begin
                    block_next[i][lane_shift +: 8] = byte_val;
                end
            end
        end

        if (cmd.len_wr)
        begin
            block_next[14] = bits_reg[63:32];
            block_next[15] = bits_reg[31:0];
        end

        if (cmd.count_bits)
        begin
            bits_next = bits_reg + 64'd8;
        end

        if (cmd.load_work)
        begin
            a_next = chain_reg[0];
            b_next = chain_reg[1];
            c_next = chain_reg[2];
            d_next = chain_reg[3];
            e_next = chain_reg[4];
        end

        // one round; the block buffer shifts down as the message schedule
        if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                block_next[i] = block_reg[i + 1];
            end
            block_next[15] = sched_new;
            a_next = temp_val;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end

        if (cmd.add_chain)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end

        if (cmd.finish)
        begin
            digest_next = chain_reg;
            chain_next  = H_INIT;
            bits_next   = '0;
        end
    end

    assign digest_word0 = digest_reg[0];
    assign digest_word1 = digest_reg[1];
    assign digest_word2 = digest_reg[2];
    assign digest_word3 = digest_reg[3];
    assign digest_word4 = digest_reg[4];

endmodule

`default_nettype wire

FILE: rtl/sha1_stream_hasher_top.sv
// top level of the streaming sha-1 hasher: controller plus datapath
//
// channel  direction  handshake                   word
// item     in         item_valid / item_stall     data_byte, byte_present, end_of_message
// digest   out        digest_valid / digest_stall digest_word0 .. digest_word4
//
// an item without a completing byte is taken in idle; a byte that fills the block starts
// a compression (80 rounds of the single round unit, then the chaining add); items stall meanwhile
// end of message: the pad byte, then zero bytes up to offset 56, then the length word,
// with one or two compressions in between, and last the digest register is loaded
// reset clears controller and bit count and loads the initial chaining value; no clearing pass
// a stalled digest holds its register; bytes are still taken, the next digest waits

`default_nettype none

module sha1_stream_hasher_top
    import sha1sh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             digest_valid,
    input  wire logic        digest_stall,
    output logic [31:0]      digest_word0,
    output logic [31:0]      digest_word1,
    output logic [31:0]      digest_word2,
    output logic [31:0]      digest_word3,
    output logic [31:0]      digest_word4
);

    dp_cmd_t cmd;

    sha1sh_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .digest_valid   (digest_valid),
        .digest_stall   (digest_stall),
        .cmd            (cmd)
    );

    sha1sh_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (data_byte),
        .digest_word0 (digest_word0),
        .digest_word1 (digest_word1),
        .digest_word2 (digest_word2),
        .digest_word3 (digest_word3),
        .digest_word4 (digest_word4)
    );

endmodule

`default_nettype wire
